/* design/dic_pkg.sv */
package dic_pkg;

    localparam int MAX_DISCS = 1024;
    localparam int AW        = $clog2(MAX_DISCS);
    localparam int CW        = $clog2(MAX_DISCS + 1);
    localparam int PW        = 2 * CW + 2;
    localparam logic [31:0] LIMIT_RESET = 32'd10000000;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_SW_RD,
        S_SW_ACC,
        S_FIN
    } t_state;

endpackage

/* design/disc_intersection_counter.sv */
// channel  | direction | handshake                | payload
// s_axis   | in        | i_s_tvalid / o_s_tready  | tdata: radius[30:0]; tlast: is_last
// m_axis   | out       | o_m_tvalid / i_m_tready  | tdata: pair_count; tuser: over_limit, dropped
// cfg      | in        | i_cfg_valid / o_cfg_ready| count_limit[31:0]
// Each disc is accepted, then the start/end count memories are read, then written.
// A set ends with a sweep over every address of both memories (one read port each,
// one multiply-accumulate), alternating read and accumulate states, then posts the result.
// After reset a clearing pass writes every address of both memories before the first request.
// A stalled result holds in the output register; the next set loads meanwhile.
module disc_intersection_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] radius, [31] zero
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] pair_count
    output logic [1:0]  o_m_tuser,   // [0] over_limit, [1] discs_dropped
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = dic_pkg::AW;
    localparam int CW = dic_pkg::CW;
    localparam int PW = dic_pkg::PW;
    localparam logic [AW-1:0] TOP = AW'(dic_pkg::MAX_DISCS - 1);

    dic_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_smem [dic_pkg::MAX_DISCS];
    logic [CW-1:0] r_emem [dic_pkg::MAX_DISCS];
    logic [CW-1:0] r_sdat, r_edat;

    logic [31:0]   r_limit;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic          r_last;
    logic          r_store;
    logic [AW-1:0] r_sidx, r_eidx;
    logic [AW-1:0] r_t;
    logic [CW-1:0] r_open;
    logic [31:0]   r_acc;
    logic          r_ovalid;
    logic [31:0]   r_odata;
    logic [1:0]    r_ouser;

    logic          accept;
    logic [AW-1:0] s_addr, e_addr;
    logic          mem_we;
    logic [CW-1:0] s_wdat, e_wdat;
    logic [30:0]   radius;
    logic [31:0]   pos_w, end_sum;
    logic [AW-1:0] sidx_c, eidx_c;
    logic [PW-1:0] term, prod;
    logic          over;

    assign radius  = i_s_tdata[30:0];
    assign accept  = i_s_tvalid && o_s_tready;
    assign pos_w   = 32'(r_cnt);
    assign end_sum = pos_w + {1'b0, radius};
    assign sidx_c  = ({1'b0, radius} <= pos_w) ? AW'(pos_w - {1'b0, radius}) : '0;
    assign eidx_c  = (end_sum >= 32'(TOP)) ? TOP : AW'(end_sum);
    assign term    = PW'({r_open, 1'b0}) + PW'(r_sdat) - PW'(1);
    assign prod    = (r_sdat == '0) ? '0 : PW'(r_sdat * term);
    assign over    = r_acc > r_limit;

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dic_pkg::S_CLR:    if (r_t == TOP) n_state = dic_pkg::S_IDLE;
            dic_pkg::S_IDLE:   if (accept) n_state = dic_pkg::S_LD_RD;
            dic_pkg::S_LD_RD:  n_state = dic_pkg::S_LD_WR;
            dic_pkg::S_LD_WR:  n_state = r_last ? dic_pkg::S_SW_RD : dic_pkg::S_IDLE;
            dic_pkg::S_SW_RD:  n_state = dic_pkg::S_SW_ACC;
            dic_pkg::S_SW_ACC: n_state = (r_t == TOP) ? dic_pkg::S_FIN : dic_pkg::S_SW_RD;
            dic_pkg::S_FIN:    if (!r_ovalid || i_m_tready) n_state = dic_pkg::S_IDLE;
            default:           n_state = dic_pkg::S_CLR;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == dic_pkg::S_IDLE);
        s_addr     = r_t;
        e_addr     = r_t;
        mem_we     = 1'b0;
        s_wdat     = '0;
        e_wdat     = '0;
        case (r_state)
            dic_pkg::S_CLR: begin
                mem_we = 1'b1;
            end
            dic_pkg::S_LD_RD: begin
                s_addr = r_sidx;
                e_addr = r_eidx;
            end
            dic_pkg::S_LD_WR: begin
                s_addr = r_sidx;
                e_addr = r_eidx;
                mem_we = r_store;
                s_wdat = r_sdat + CW'(1);
                e_wdat = r_edat + CW'(1);
            end
            dic_pkg::S_SW_ACC: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_smem[s_addr] <= s_wdat;
            r_emem[e_addr] <= e_wdat;
        end
        r_sdat <= r_smem[s_addr];
        r_edat <= r_emem[e_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dic_pkg::S_CLR;
            r_limit  <= dic_pkg::LIMIT_RESET;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_t      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (r_ovalid && i_m_tready && r_state != dic_pkg::S_FIN) r_ovalid <= 1'b0;
            case (r_state)
                dic_pkg::S_CLR: begin
                    r_t <= r_t + AW'(1);
                end
                dic_pkg::S_IDLE: begin
                    if (accept) begin
                        r_last  <= i_s_tlast;
                        r_sidx  <= sidx_c;
                        r_eidx  <= eidx_c;
                        r_store <= (r_cnt != CW'(dic_pkg::MAX_DISCS));
                        if (r_cnt == CW'(dic_pkg::MAX_DISCS)) r_drop <= 1'b1;
                    end
                end
                dic_pkg::S_LD_WR: begin
                    if (r_store) r_cnt <= r_cnt + CW'(1);
                    r_t    <= '0;
                    r_open <= '0;
                    r_acc  <= '0;
                end
                dic_pkg::S_SW_ACC: begin
                    if (CW'(r_t) < r_cnt) begin
                        r_acc  <= r_acc + 32'(prod[PW-1:1]);
                        r_open <= r_open + r_sdat - r_edat;
                    end
                    r_t <= r_t + AW'(1);
                end
                dic_pkg::S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= over ? 32'd0 : r_acc;
                        r_ouser  <= {r_drop, over};
                        r_cnt    <= '0;
                        r_drop   <= 1'b0;
                    end
                end
                default: begin
                    r_t <= r_t;
                end
            endcase
        end
    end

endmodule

/* design/dic_checker.sv */
module dic_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_over_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("over limit result carries a count");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after a request");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> ##2 !o_s_tready)
        else $error("ready during count");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind disc_intersection_counter dic_props u_dic_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_cfg_ready(o_cfg_ready)
);
